// File: src/vpp_pkg.sv
// Shared types and fixed widths for the vertex perspective projection pipeline.
package vpp_pkg;
   localparam int VERT_W   = 24;
   localparam int COEF_W   = 32;
   localparam int PROD_W   = COEF_W + VERT_W;     // one coefficient times one coordinate
   localparam int SUM_W    = PROD_W + 2;          // three products plus translation
   localparam int NUM_W    = SUM_W + 1;           // x + w or w - y, also 2w
   localparam int SIZE_W   = 14;
   localparam int SCALED_W = NUM_W + SIZE_W;      // size times numerator magnitude
   localparam int QUO_W    = 24;
   localparam int REM_W    = NUM_W + QUO_W;       // room for den shifted by QUO_W
   localparam int DEPTH_W  = 32;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW_X_FIRST  = 4'd0,
      REG_ROW_X_SECOND = 4'd1,
      REG_ROW_Y_FIRST  = 4'd2,
      REG_ROW_Y_SECOND = 4'd3,
      REG_ROW_W_FIRST  = 4'd4,
      REG_ROW_W_SECOND = 4'd5,
      REG_SCREEN_W     = 4'd6,
      REG_SCREEN_H     = 4'd7
   } csr_index_type;

   // one division lane between restoring steps
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [NUM_W-1:0] den;
      logic [QUO_W-1:0] quo;
      logic             neg;
      logic             sat;
   } div_lane_type;

   // payload that rides alongside the divisions
   typedef struct packed {
      logic                      off;
      logic signed [DEPTH_W-1:0] depth;
   } side_type;
endpackage

// File: src/vertex_perspective_project.sv
// Vertex perspective projection: matrix rows, near test, viewport divide.
//
// Usage: program the six matrix row words (two signed Q16.16 coefficients
// each) and the screen size through the csr_ channel while the block is idle;
// csr_ready is always high and writes beyond the eighth register are dropped.
// Push one vertex per cycle with req_start; req_busy stays low, so a word is
// taken at every edge where req_start is high.
// Each result word appears on the rsp_ ports for one cycle with rsp_valid
// high, after its vertex passes the registers for multiply, sum, numerator,
// scale multiply, range check, 24 restoring divide steps (one quotient bit
// per stage) and the output register. Throughput is one vertex per cycle,
// set by the fully pipelined divider, one stage per quotient bit.
// Results leave in input order. The receiver cannot stall, so nothing holds
// the pipe.
// Reset (synchronous, active high) clears all valid bits and the matrix,
// and sets both screen sizes to one.
module vertex_perspective_project #(
   parameter int OFFSCREEN_COORD = 30000,
   parameter int COEF_FRAC_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_start,
   output logic                                  req_busy,
   input  logic signed [vpp_pkg::VERT_W-1:0]     req_vert_x,
   input  logic signed [vpp_pkg::VERT_W-1:0]     req_vert_y,
   input  logic signed [vpp_pkg::VERT_W-1:0]     req_vert_z,
   output logic                                  rsp_valid,
   output logic signed [vpp_pkg::QUO_W-1:0]      rsp_screen_x,
   output logic signed [vpp_pkg::QUO_W-1:0]      rsp_screen_y,
   output logic signed [vpp_pkg::DEPTH_W-1:0]    rsp_depth_w,
   output logic                                  rsp_off_screen,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [vpp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [vpp_pkg::CSR_DAT_W-1:0]         csr_wdata
);
   import vpp_pkg::*;

   // near threshold: w <= ((256 << F) - 1) / 990
   localparam longint NEAR_LIMIT = ((longint'(256) << COEF_FRAC_BITS) - 1) / 990;
   localparam int     STEPS      = QUO_W;
   localparam int     LATENCY    = STEPS + 6;
   localparam logic signed [QUO_W-1:0] OFF_COORD = QUO_W'(OFFSCREEN_COORD);
   localparam logic signed [QUO_W-1:0] COORD_MAX = {1'b0, {(QUO_W-1){1'b1}}};
   localparam logic signed [QUO_W-1:0] COORD_MIN = {1'b1, {(QUO_W-1){1'b0}}};
   localparam logic [QUO_W-1:0]        NEG_LIMIT = {1'b1, {(QUO_W-1){1'b0}}};

   // ---------------- configuration registers ----------------
   logic [CSR_DAT_W-1:0] row_ff [0:5];
   logic [SIZE_W-1:0]    width_ff, height_ff;

   assign csr_ready = 1'b1;
   assign req_busy  = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) row_ff[i] <= '0;
         width_ff  <= SIZE_W'(1);
         height_ff <= SIZE_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_ROW_X_FIRST:  row_ff[0] <= csr_wdata;
            REG_ROW_X_SECOND: row_ff[1] <= csr_wdata;
            REG_ROW_Y_FIRST:  row_ff[2] <= csr_wdata;
            REG_ROW_Y_SECOND: row_ff[3] <= csr_wdata;
            REG_ROW_W_FIRST:  row_ff[4] <= csr_wdata;
            REG_ROW_W_SECOND: row_ff[5] <= csr_wdata;
            REG_SCREEN_W:     width_ff  <= csr_wdata[SIZE_W-1:0];
            REG_SCREEN_H:     height_ff <= csr_wdata[SIZE_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // ---------------- stage 1: nine coefficient products ----------------
   logic                     v1_ff;
   logic signed [PROD_W-1:0] mul_ff   [0:2][0:2];
   logic signed [COEF_W-1:0] trans_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= req_start;
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         mul_ff[r][0] <= $signed(row_ff[2*r][31:0])    * req_vert_x;
         mul_ff[r][1] <= $signed(row_ff[2*r][63:32])   * req_vert_y;
         mul_ff[r][2] <= $signed(row_ff[2*r+1][31:0])  * req_vert_z;
         trans_ff[r]  <= $signed(row_ff[2*r+1][63:32]);
      end
   end

   // ---------------- stage 2: row sums ----------------
   logic                    v2_ff;
   logic signed [SUM_W-1:0] sum_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++)
         sum_ff[r] <= SUM_W'(mul_ff[r][0]) + SUM_W'(mul_ff[r][1])
                    + SUM_W'(mul_ff[r][2]) + SUM_W'(trans_ff[r]);
   end

   // ---------------- stage 3: numerators, near test, depth ----------------
   logic                    v3_ff;
   logic [NUM_W-1:0]        mag_x_ff, mag_y_ff, den3_ff;
   logic                    neg_x3_ff, neg_y3_ff;
   side_type                side3_ff;

   logic signed [NUM_W-1:0] num_x, num_y;
   logic [SUM_W-1:0]        w_mag, d_mag;
   side_type                side3_in;

   always_comb begin
      num_x = NUM_W'(sum_ff[0]) + NUM_W'(sum_ff[2]);
      num_y = NUM_W'(sum_ff[2]) - NUM_W'(sum_ff[1]);
      w_mag = sum_ff[2][SUM_W-1] ? SUM_W'(-sum_ff[2]) : SUM_W'(sum_ff[2]);
      d_mag = w_mag >> COEF_FRAC_BITS;
      side3_in.off = (sum_ff[2] <= SUM_W'(NEAR_LIMIT));
      // saturate depth to 32 bits, toward the sign of w
      if (sum_ff[2][SUM_W-1])
         side3_in.depth = (d_mag > SUM_W'(64'h8000_0000)) ? $signed(32'h8000_0000)
                                                          : DEPTH_W'(-d_mag);
      else
         side3_in.depth = (d_mag > SUM_W'(64'h7FFF_FFFF)) ? $signed(32'h7FFF_FFFF)
                                                          : DEPTH_W'(d_mag);
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      neg_x3_ff <= num_x[NUM_W-1];
      neg_y3_ff <= num_y[NUM_W-1];
      mag_x_ff  <= num_x[NUM_W-1] ? NUM_W'(-num_x) : NUM_W'(num_x);
      mag_y_ff  <= num_y[NUM_W-1] ? NUM_W'(-num_y) : NUM_W'(num_y);
      den3_ff   <= {sum_ff[2][SUM_W-1:0], 1'b0};
      side3_ff  <= side3_in;
   end

   // ---------------- stage 4: scale by screen size ----------------
   logic                v4_ff;
   logic [SCALED_W-1:0] scl_x_ff, scl_y_ff;
   logic [NUM_W-1:0]    den4_ff;
   logic                neg_x4_ff, neg_y4_ff;
   side_type            side4_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= v3_ff;
   end

   always_ff @(posedge clock) begin
      scl_x_ff  <= SCALED_W'(width_ff)  * SCALED_W'(mag_x_ff);
      scl_y_ff  <= SCALED_W'(height_ff) * SCALED_W'(mag_y_ff);
      den4_ff   <= den3_ff;
      neg_x4_ff <= neg_x3_ff;
      neg_y4_ff <= neg_y3_ff;
      side4_ff  <= side3_ff;
   end

   // ---------------- stage 5: range check, then restoring divide ----------------
   logic         dv_ff   [0:STEPS];
   div_lane_type lx_ff   [0:STEPS];
   div_lane_type ly_ff   [0:STEPS];
   side_type     side_ff [0:STEPS];

   logic [REM_W-1:0] den_top;
   assign den_top = {den4_ff, {QUO_W{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= 1'b0;
      else       dv_ff[0] <= v4_ff;
   end

   always_ff @(posedge clock) begin
      // quotient at or past 2^24 clamps either way
      lx_ff[0].rem <= REM_W'(scl_x_ff);
      lx_ff[0].den <= den4_ff;
      lx_ff[0].quo <= '0;
      lx_ff[0].neg <= neg_x4_ff;
      lx_ff[0].sat <= (REM_W'(scl_x_ff) >= den_top);
      ly_ff[0].rem <= REM_W'(scl_y_ff);
      ly_ff[0].den <= den4_ff;
      ly_ff[0].quo <= '0;
      ly_ff[0].neg <= neg_y4_ff;
      ly_ff[0].sat <= (REM_W'(scl_y_ff) >= den_top);
      side_ff[0]   <= side4_ff;
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_div
      localparam int BIT = STEPS - 1 - k;
      logic [REM_W-1:0] trial_x, trial_y;
      div_lane_type     nx, ny;

      always_comb begin
         trial_x = REM_W'(lx_ff[k].den) << BIT;
         trial_y = REM_W'(ly_ff[k].den) << BIT;
         nx = lx_ff[k];
         ny = ly_ff[k];
         if (lx_ff[k].rem >= trial_x) begin
            nx.rem      = lx_ff[k].rem - trial_x;
            nx.quo[BIT] = 1'b1;
         end
         if (ly_ff[k].rem >= trial_y) begin
            ny.rem      = ly_ff[k].rem - trial_y;
            ny.quo[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_ff[k+1] <= 1'b0;
         else       dv_ff[k+1] <= dv_ff[k];
      end

      always_ff @(posedge clock) begin
         lx_ff[k+1]   <= nx;
         ly_ff[k+1]   <= ny;
         side_ff[k+1] <= side_ff[k];
      end
   end

   // ---------------- output stage: sign, clamp, off-screen select ----------------
   function automatic logic signed [QUO_W-1:0] clamp_coord(div_lane_type l);
      logic signed [QUO_W-1:0] res;
      if (l.neg)
         res = (l.sat || l.quo > NEG_LIMIT) ? COORD_MIN : QUO_W'(-l.quo);
      else
         res = (l.sat || l.quo[QUO_W-1]) ? COORD_MAX : $signed(l.quo);
      return res;
   endfunction

   logic                    rsp_valid_ff, off_ff;
   logic signed [QUO_W-1:0] sx_ff, sy_ff;
   logic signed [DEPTH_W-1:0] depth_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= dv_ff[STEPS];
   end

   always_ff @(posedge clock) begin
      off_ff   <= side_ff[STEPS].off;
      depth_ff <= side_ff[STEPS].depth;
      sx_ff    <= side_ff[STEPS].off ? OFF_COORD : clamp_coord(lx_ff[STEPS]);
      sy_ff    <= side_ff[STEPS].off ? OFF_COORD : clamp_coord(ly_ff[STEPS]);
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_screen_x   = sx_ff;
   assign rsp_screen_y   = sy_ff;
   assign rsp_depth_w    = depth_ff;
   assign rsp_off_screen = off_ff;

   // ---------------- assertions ----------------
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_start |-> ##LATENCY rsp_valid)
      else $error("vertex did not produce a result at the pipeline latency");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_start, LATENCY))
      else $error("result without a matching vertex");

   a_off_coords: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_off_screen) |->
         (rsp_screen_x == OFF_COORD && rsp_screen_y == OFF_COORD))
      else $error("off-screen result carries projected coordinates");

   a_on_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_off_screen) |-> !rsp_depth_w[DEPTH_W-1])
      else $error("on-screen result with negative depth");
endmodule
